// ----- src/adfr_pkg.sv -----
// Shared constants and types for the addressed display frame receiver.
// No dependencies; used by every module under src.
package adfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 4;
    localparam int FCNT_W    = 2;
    localparam int DISPLAY_W = 64;

    localparam logic [BYTE_W-1:0] START_BYTE       = 8'hBA;
    localparam logic [BYTE_W-1:0] END_BYTE         = 8'hBE;
    localparam logic [FCNT_W-1:0] ADDRESS_POSITION = 2'd2;
    localparam logic [FCNT_W-1:0] COUNT_LIMIT      = 2'd3;

    typedef struct packed {
        logic              store;
        logic [CNT_W-1:0]  slot;
        logic              commit;
    } t_frame_ctl;

endpackage

// ----- src/addressed_display_frame_receiver.sv -----
// Addressed display frame receiver, top level: input register, frame control,
// payload store and result register. Depends on adfr_pkg, adfr_frame_ctrl, adfr_payload_store.
// Each byte passes the input register, then the result register; an unaccepted result stalls both.
// Throughput 1 item per cycle while results are accepted, set by the frame state update between
// input and result registers.
// Reset (i_rst_n low, synchronous): frame closed, counters zero, display cleared,
// station address zero, both stream stages empty.
module addressed_display_frame_receiver #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // [7:0] rx_byte
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [63:0]                     o_m_axis_tdata,   // [63:0] display_word
    output logic [1:0]                      o_m_axis_tuser,   // [0] committed, [1] in_frame
    input  logic                            i_cfg_wr_en,
    input  logic [7:0]                      i_cfg_wr_data     // [7:0] station_address
);

    logic                            r_in_valid;
    logic [adfr_pkg::BYTE_W-1:0]     r_in_byte;
    logic [adfr_pkg::BYTE_W-1:0]     r_station_address;
    logic                            r_out_valid;
    logic                            r_committed;
    logic                            r_in_frame;

    logic                            step;
    logic                            in_frame_next;
    adfr_pkg::t_frame_ctl            ctl;
    logic [adfr_pkg::DISPLAY_W-1:0]  display_word;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station_address <= '0;
        end else if (i_cfg_wr_en) begin
            r_station_address <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    adfr_frame_ctrl #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_frame_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_rx_byte         (r_in_byte),
        .i_station_address (r_station_address),
        .o_ctl             (ctl),
        .o_in_frame        (in_frame_next)
    );

    adfr_payload_store #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_payload_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_rx_byte      (r_in_byte),
        .i_ctl          (ctl),
        .o_display_word (display_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold flags while the result waits
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_committed <= ctl.commit;
            r_in_frame  <= in_frame_next;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = display_word;
    assign o_m_axis_tuser  = {r_in_frame, r_committed};

endmodule

// ----- src/adfr_frame_ctrl.sv -----
// Frame tracking for the receiver: start/address/end decode and counters.
// Depends on adfr_pkg; drives the payload store through adfr_pkg::t_frame_ctl.
module adfr_frame_ctrl #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [adfr_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic [adfr_pkg::BYTE_W-1:0]   i_station_address,
    output adfr_pkg::t_frame_ctl          o_ctl,
    output logic                          o_in_frame
);

    localparam logic [adfr_pkg::CNT_W-1:0] PAYLOAD_CNT = adfr_pkg::CNT_W'(PAYLOAD_BYTES);

    logic                          r_frame_open;
    logic [adfr_pkg::FCNT_W-1:0]   r_frame_byte_count;
    logic                          r_capture_enabled;
    logic [adfr_pkg::CNT_W-1:0]    r_payload_count;

    logic                          n_frame_open;
    logic [adfr_pkg::FCNT_W-1:0]   n_frame_byte_count;
    logic                          n_capture_enabled;
    logic [adfr_pkg::CNT_W-1:0]    n_payload_count;

    logic                          open_now;
    logic [adfr_pkg::FCNT_W-1:0]   fcnt_step;
    logic                          addr_hit;
    logic                          other_byte;
    logic                          store;
    logic [adfr_pkg::CNT_W-1:0]    pcnt_step;
    logic                          finish;

    always_comb begin
        open_now   = r_frame_open || (i_rx_byte == adfr_pkg::START_BYTE);
        fcnt_step  = r_frame_byte_count;
        if (open_now && (r_frame_byte_count < adfr_pkg::COUNT_LIMIT)) begin
            fcnt_step = r_frame_byte_count + 1'b1;
        end
        addr_hit   = open_now && (fcnt_step == adfr_pkg::ADDRESS_POSITION)
                     && (i_rx_byte == i_station_address);
        other_byte = open_now && !addr_hit;
        store      = other_byte && r_capture_enabled && (r_payload_count < PAYLOAD_CNT);
        pcnt_step  = r_payload_count + adfr_pkg::CNT_W'(store);
        finish     = other_byte && (i_rx_byte == adfr_pkg::END_BYTE);

        if (finish) begin
            n_frame_open       = 1'b0;
            n_frame_byte_count = '0;
            n_capture_enabled  = 1'b0;
            n_payload_count    = '0;
        end else begin
            n_frame_open       = open_now;
            n_frame_byte_count = fcnt_step;
            n_capture_enabled  = r_capture_enabled || addr_hit;
            n_payload_count    = pcnt_step;
        end

        o_ctl.store  = store;
        o_ctl.slot   = r_payload_count;
        o_ctl.commit = finish && (pcnt_step == PAYLOAD_CNT);
        o_in_frame   = n_frame_open;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open       <= 1'b0;
            r_frame_byte_count <= '0;
            r_capture_enabled  <= 1'b0;
            r_payload_count    <= '0;
        end else if (i_step) begin
            r_frame_open       <= n_frame_open;
            r_frame_byte_count <= n_frame_byte_count;
            r_capture_enabled  <= n_capture_enabled;
            r_payload_count    <= n_payload_count;
        end
    end

endmodule

// ----- src/adfr_payload_store.sv -----
// Payload buffer and display contents of the receiver.
// Depends on adfr_pkg; controlled by adfr_frame_ctrl.
module adfr_payload_store #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [adfr_pkg::BYTE_W-1:0]     i_rx_byte,
    input  adfr_pkg::t_frame_ctl            i_ctl,
    output logic [adfr_pkg::DISPLAY_W-1:0]  o_display_word
);

    localparam int SLOT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    logic [adfr_pkg::BYTE_W-1:0] r_buf  [PAYLOAD_BYTES];
    logic [adfr_pkg::BYTE_W-1:0] r_disp [PAYLOAD_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_step && i_ctl.store) begin
            r_buf[i_ctl.slot[SLOT_W-1:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                r_disp[k] <= '0;
            end
        end else if (i_step && i_ctl.commit) begin
            for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                if (i_ctl.store && (i_ctl.slot[SLOT_W-1:0] == SLOT_W'(k))) begin
                    r_disp[k] <= i_rx_byte;
                end else begin
                    r_disp[k] <= r_buf[k];
                end
            end
        end
    end

    always_comb begin
        o_display_word = '0;
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            o_display_word[k*adfr_pkg::BYTE_W +: adfr_pkg::BYTE_W] = r_disp[k];
        end
    end

endmodule

// ----- tb/sv/addressed_display_frame_receiver_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for addressed_display_frame_receiver: drives received bytes,
// predicts the display word and frame flags per byte, and compares every result.
// Depends on adfr_pkg and the addressed_display_frame_receiver top level.
module addressed_display_frame_receiver_tb;

    localparam int PAYLOAD_BYTES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic        committed;
        logic [63:0] display_word;
        logic        in_frame;
    } t_frame_outcome;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;   // [7:0] rx_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;         // [63:0] display_word
    logic [1:0]  o_m_axis_tuser;         // [0] committed, [1] in_frame
    logic        i_cfg_wr_en     = 1'b0;
    logic [7:0]  i_cfg_wr_data   = '0;   // [7:0] station_address

    addressed_display_frame_receiver #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always #6 i_clk = ~i_clk;

    // receiver state mirror
    logic [7:0]                  rx_address   = '0;
    logic                        rx_open      = 1'b0;
    logic [adfr_pkg::FCNT_W-1:0] rx_frame_cnt = '0;
    logic                        rx_capture   = 1'b0;
    logic [adfr_pkg::CNT_W-1:0]  rx_pay_cnt   = '0;
    logic [63:0]                 rx_buffer    = '0;
    logic [63:0]                 rx_display   = '0;

    t_frame_outcome expected_outcomes[$];
    t_frame_outcome oldest_outcome;

    int src_idle_pct  = 0;
    int snk_idle_pct  = 0;
    int snk_hold_left = 0;
    int n_sent        = 0;
    int n_results     = 0;
    int n_commits     = 0;
    int n_fail        = 0;
    int cycle_count   = 0;

    function automatic t_frame_outcome predict_rx_byte(input logic [7:0] b);
        t_frame_outcome r;
        r.committed = 1'b0;
        if (!rx_open && b == adfr_pkg::START_BYTE) rx_open = 1'b1;
        if (rx_open) begin
            if (rx_frame_cnt < adfr_pkg::COUNT_LIMIT) rx_frame_cnt = rx_frame_cnt + 1'b1;
            if (rx_frame_cnt == adfr_pkg::ADDRESS_POSITION && b == rx_address) begin
                rx_capture = 1'b1;
            end else begin
                if (rx_capture && rx_pay_cnt < PAYLOAD_BYTES) begin
                    rx_buffer[8*rx_pay_cnt[2:0] +: 8] = b;
                    rx_pay_cnt = rx_pay_cnt + 1'b1;
                end
                if (b == adfr_pkg::END_BYTE) begin
                    if (rx_pay_cnt == PAYLOAD_BYTES) begin
                        rx_display  = rx_buffer;
                        r.committed = 1'b1;
                    end
                    rx_buffer    = '0;
                    rx_capture   = 1'b0;
                    rx_open      = 1'b0;
                    rx_frame_cnt = '0;
                    rx_pay_cnt   = '0;
                end
            end
        end
        r.display_word = rx_display;
        r.in_frame     = rx_open;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < src_idle_pct) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_outcomes.push_back(predict_rx_byte(b));
        n_sent++;
    endtask

    task automatic wait_for_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_station_address(input logic [7:0] addr);
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        rx_address = addr;
    endtask

    task automatic send_random_frame();
        int kind;
        int len;
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end else begin
            send_byte(adfr_pkg::START_BYTE);
            send_byte(kind < 85 ? rx_address : 8'($urandom));
            len = (kind < 60) ? PAYLOAD_BYTES - 1 : $urandom_range(0, PAYLOAD_BYTES + 2);
            repeat (len) send_byte(($urandom_range(19) == 0) ? adfr_pkg::START_BYTE
                                                              : 8'($urandom));
            if (kind % 10 != 0) send_byte(adfr_pkg::END_BYTE);
        end
    endtask

    task automatic test_bytes_outside_frame();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(adfr_pkg::END_BYTE);
    endtask

    // start byte reused inside, address value seen again late, ninth byte dropped
    task automatic test_full_payload_with_overflow();
        logic [7:0] frame_bytes[12];
        frame_bytes = '{adfr_pkg::START_BYTE, 8'h00, adfr_pkg::START_BYTE, 8'hFF, 8'h01,
                        8'h80, 8'h7F, 8'h00, 8'h55, 8'hAA, 8'h33, adfr_pkg::END_BYTE};
        foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
    endtask

    task automatic test_unaddressed_short_frame();
        send_byte(adfr_pkg::START_BYTE);
        send_byte(8'h12);
        send_byte(adfr_pkg::END_BYTE);
        send_byte(adfr_pkg::START_BYTE);
        send_byte(8'h00);
        send_byte(adfr_pkg::END_BYTE);
    endtask

    task automatic test_address_equals_end_byte();
        write_station_address(adfr_pkg::END_BYTE);
        send_byte(adfr_pkg::START_BYTE);
        send_byte(adfr_pkg::END_BYTE);
        for (int k = 1; k < PAYLOAD_BYTES; k++) send_byte(8'(k * 37));
        send_byte(adfr_pkg::END_BYTE);
    endtask

    task automatic test_random_frames(input int count, input logic [7:0] addr,
                                      input int src_pct, input int snk_pct);
        int stop_at;
        write_station_address(addr);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at      = n_sent + count;
        while (n_sent < stop_at) send_random_frame();
    endtask

    task automatic test_receiver_hold_off();
        int stop_at;
        write_station_address(8'h00);
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        snk_hold_left = 300;
        stop_at       = n_sent + 60;
        while (n_sent < stop_at) send_random_frame();
        wait_for_results();
        repeat (20) @(posedge i_clk);
        stop_at = n_sent + 30;
        while (n_sent < stop_at) send_random_frame();
    endtask

    always @(posedge i_clk) begin
        if (snk_hold_left > 0) begin
            snk_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_outcomes.size() == 0) begin
                $error("unexpected result: display_word %h tuser %b",
                       o_m_axis_tdata, o_m_axis_tuser);
                n_fail++;
            end else begin
                oldest_outcome = expected_outcomes.pop_front();
                n_results++;
                if (oldest_outcome.committed) n_commits++;
                if (o_m_axis_tuser[0] !== oldest_outcome.committed) begin
                    $error("committed: expected %b, actual %b",
                           oldest_outcome.committed, o_m_axis_tuser[0]);
                    n_fail++;
                end
                if (o_m_axis_tdata !== oldest_outcome.display_word) begin
                    $error("display_word: expected %h, actual %h",
                           oldest_outcome.display_word, o_m_axis_tdata);
                    n_fail++;
                end
                if (o_m_axis_tuser[1] !== oldest_outcome.in_frame) begin
                    $error("in_frame: expected %b, actual %b",
                           oldest_outcome.in_frame, o_m_axis_tuser[1]);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_bytes_outside_frame();
        test_full_payload_with_overflow();
        test_unaddressed_short_frame();
        test_address_equals_end_byte();
        test_random_frames(480, 8'($urandom), 9, 84);
        test_random_frames(480, 8'hFF, 84, 9);
        test_random_frames(440, adfr_pkg::START_BYTE, 0, 0);
        test_receiver_hold_off();

        wait_for_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes across directed frames, random frames and a long output stall;",
                 n_sent);
        $display("checked %0d results, %0d of which committed a full payload to the display.",
                 n_results, n_commits);
        if (n_fail == 0 && expected_outcomes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
